### rtl/core/masked_image_gradient_unit_defines.svh
// Assertion helpers shared by the gradient unit.
`ifndef MASKED_IMAGE_GRADIENT_UNIT_DEFINES_SVH
`define MASKED_IMAGE_GRADIENT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mig: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MIG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mig: next-cycle check failed");

`endif

### rtl/core/mig_pkg.sv
`timescale 1ns / 1ps

package mig_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int CHANNELS   = 3;
    localparam int MAX_ROWS   = 1024;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W0    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CMP_W     = (ROW_W + 1 > CMP_W0) ? ROW_W + 1 : CMP_W0;

    localparam int IN_CH_W   = 16;
    localparam int IN_CH_N   = 3;
    localparam int IN_USE    = (CHANNELS < IN_CH_N) ? CHANNELS : IN_CH_N;
    localparam int IN_EXT_W  = (PIXEL_BITS > IN_CH_W) ? PIXEL_BITS : IN_CH_W;
    localparam int IN_DATA_W = IN_CH_N * IN_CH_W;

    localparam int OUT_CH     = 3;
    localparam int GCH        = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam int POS_OUT_W  = 10;
    localparam int GRAD_W     = PIXEL_BITS + 2;
    localparam int GOUT_W     = 18;
    localparam int OUT_DATA_W = 2 * POS_OUT_W + 2 * OUT_CH * GOUT_W;
    localparam int EMITS      = 3;

    localparam int PIX_W = 1 + CHANNELS * PIXEL_BITS;

    localparam logic [CFG_W-1:0] CFG_WIDTH_RST  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RST = CFG_W'(MAX_ROWS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [COL_W-1:0]            t_col;
    typedef logic [ROW_W-1:0]            t_row;
    typedef logic [CMP_W-1:0]            t_cmp;
    typedef logic [PIXEL_BITS-1:0]       t_chan;
    typedef logic [IN_EXT_W-1:0]         t_inext;
    typedef logic signed [GOUT_W-1:0]    t_gout;
    typedef logic [POS_OUT_W-1:0]        t_pout;

    typedef struct packed {
        logic                        mask;
        logic [CHANNELS-1:0][PIXEL_BITS-1:0] ch;
    } t_pix;

    // Position of one step and the neighbor conditions that follow from it.
    typedef struct packed {
        t_row row;
        t_col col;
        logic has_left;
        logic has_left2;
        logic has_right;
        logic row_ge1;
        logic row_ge2;
        logic last_row;
        logic last_col;
    } t_pos;

    // Laid out as the output word: row in the lowest bits, gy[2] on top.
    typedef struct packed {
        t_gout [OUT_CH-1:0] gy;
        t_gout [OUT_CH-1:0] gx;
        t_pout              col;
        t_pout              row;
    } t_res;

    function automatic logic signed [GRAD_W-1:0] axis_grad(
        input logic [PIXEL_BITS-1:0] lo,
        input logic [PIXEL_BITS-1:0] mid,
        input logic [PIXEL_BITS-1:0] hi,
        input logic                  lo_ok,
        input logic                  hi_ok
    );
        logic signed [GRAD_W-1:0] sl;
        logic signed [GRAD_W-1:0] sm;
        logic signed [GRAD_W-1:0] sh;
        logic signed [GRAD_W-1:0] res;
        sl = GRAD_W'(signed'(lo));
        sm = GRAD_W'(signed'(mid));
        sh = GRAD_W'(signed'(hi));
        priority if (lo_ok && hi_ok) begin
            res = sh - sl;
        end else if (lo_ok) begin
            res = (sm - sl) <<< 1;
        end else if (hi_ok) begin
            res = (sh - sm) <<< 1;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

### rtl/core/mig_ram.sv
`timescale 1ns / 1ps

module mig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic             i_re,
    input  logic [AW-1:0]    i_ra0,
    input  logic [AW-1:0]    i_ra1,
    output logic [WIDTH-1:0] o_rd0,
    output logic [WIDTH-1:0] o_rd1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    // Read returns the old word on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd0 <= r_mem[i_ra0];
            r_rd1 <= r_mem[i_ra1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

### rtl/core/mig_pos.sv
`timescale 1ns / 1ps

module mig_pos (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mig_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mig_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_step,
    output mig_pkg::t_pos                  o_pos
);

    logic [mig_pkg::CFG_W-1:0] r_width;
    logic [mig_pkg::CFG_W-1:0] r_height;
    mig_pkg::t_col r_col;
    mig_pkg::t_col n_col;
    mig_pkg::t_row r_row;
    mig_pkg::t_row n_row;
    mig_pkg::t_cmp eff_w;
    mig_pkg::t_cmp eff_h;
    mig_pkg::t_cmp cw;
    mig_pkg::t_cmp chh;
    mig_pkg::t_cmp col0;
    mig_pkg::t_cmp row1;
    mig_pkg::t_cmp col_c;
    mig_pkg::t_cmp row_c;
    mig_pkg::t_cmp col_nx;
    mig_pkg::t_cmp row_nx;
    logic          col_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mig_pkg::CFG_WIDTH_RST;
            r_height <= mig_pkg::CFG_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (mig_pkg::t_cfg_reg'(i_cfg_idx))
                mig_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                mig_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        cw    = mig_pkg::t_cmp'(r_width);
        chh   = mig_pkg::t_cmp'(r_height);
        eff_w = (cw == '0) ? mig_pkg::t_cmp'(1) :
                (cw > mig_pkg::t_cmp'(mig_pkg::MAX_WIDTH)) ?
                mig_pkg::t_cmp'(mig_pkg::MAX_WIDTH) : cw;
        eff_h = (chh == '0) ? mig_pkg::t_cmp'(1) :
                (chh > mig_pkg::t_cmp'(mig_pkg::MAX_ROWS)) ?
                mig_pkg::t_cmp'(mig_pkg::MAX_ROWS) : chh;

        // Wrap a position left out of range by a narrowed frame.
        col0     = mig_pkg::t_cmp'(r_col);
        col_wrap = (col0 >= eff_w);
        col_c    = col_wrap ? '0 : col0;
        row1     = mig_pkg::t_cmp'(r_row) + mig_pkg::t_cmp'(col_wrap);
        row_c    = (row1 >= eff_h) ? '0 : row1;

        col_nx = col_c + mig_pkg::t_cmp'(1);
        row_nx = row_c + mig_pkg::t_cmp'(1);
        if (col_nx >= eff_w) begin
            n_col = '0;
            n_row = (row_nx >= eff_h) ? '0 : mig_pkg::t_row'(row_nx);
        end else begin
            n_col = mig_pkg::t_col'(col_nx);
            n_row = mig_pkg::t_row'(row_c);
        end

        o_pos.row       = mig_pkg::t_row'(row_c);
        o_pos.col       = mig_pkg::t_col'(col_c);
        o_pos.has_left  = (col_c != '0);
        o_pos.has_left2 = (col_c >= mig_pkg::t_cmp'(2));
        o_pos.has_right = (col_nx < eff_w);
        o_pos.row_ge1   = (row_c != '0);
        o_pos.row_ge2   = (row_c >= mig_pkg::t_cmp'(2));
        o_pos.last_row  = (row_nx == eff_h);
        o_pos.last_col  = (col_nx == eff_w);
    end

endmodule

### rtl/core/mig_grad.sv
`timescale 1ns / 1ps

module mig_grad (
    input  mig_pkg::t_pix  i_mid,
    input  mig_pkg::t_pix  i_left,
    input  mig_pkg::t_pix  i_right,
    input  mig_pkg::t_pix  i_top,
    input  mig_pkg::t_pix  i_bottom,
    input  logic           i_left_ok,
    input  logic           i_right_ok,
    input  logic           i_top_ok,
    input  logic           i_bottom_ok,
    input  mig_pkg::t_pout i_row,
    input  mig_pkg::t_pout i_col,
    output mig_pkg::t_res  o_res
);

    logic lx;
    logic rx;
    logic ty;
    logic by;

    // A neighbor counts only when it lies in the frame and in the mask.
    assign lx = i_left_ok   && i_left.mask;
    assign rx = i_right_ok  && i_right.mask;
    assign ty = i_top_ok    && i_top.mask;
    assign by = i_bottom_ok && i_bottom.mask;

    always_comb begin
        o_res     = '0;
        o_res.row = i_row;
        o_res.col = i_col;
        for (int k = 0; k < mig_pkg::GCH; k++) begin
            o_res.gx[k] = mig_pkg::t_gout'(mig_pkg::axis_grad(
                i_left.ch[k], i_mid.ch[k], i_right.ch[k], lx, rx));
            o_res.gy[k] = mig_pkg::t_gout'(mig_pkg::axis_grad(
                i_top.ch[k], i_mid.ch[k], i_bottom.ch[k], ty, by));
        end
    end

endmodule

### rtl/core/mig_out.sv
`timescale 1ns / 1ps

module mig_out (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic [mig_pkg::EMITS-1:0]             i_valid,
    input  mig_pkg::t_res [mig_pkg::EMITS-1:0]    i_res,
    output logic                                  o_free,
    output logic                                  o_tvalid,
    input  logic                                  i_tready,
    output logic [mig_pkg::OUT_DATA_W-1:0]        o_tdata,
    output logic                                  o_tlast
);

    logic [mig_pkg::EMITS-1:0]          r_v;
    mig_pkg::t_res [mig_pkg::EMITS-1:0] r_res;
    logic [mig_pkg::EMITS-1:0]          sel_oh;
    logic [mig_pkg::EMITS-1:0]          rest;
    mig_pkg::t_res                      sel;
    logic                               fire;

    // Present the lowest pending result; results of one pixel leave in raster order.
    always_comb begin
        sel_oh = r_v & (~r_v + mig_pkg::EMITS'(1));
        rest   = r_v & ~sel_oh;
        sel    = '0;
        for (int i = 0; i < mig_pkg::EMITS; i++) begin
            if (sel_oh[i]) begin
                sel = sel | r_res[i];
            end
        end
    end

    assign o_tvalid = (r_v != '0);
    assign fire     = o_tvalid && i_tready;
    assign o_tlast  = (rest == '0);
    assign o_tdata  = {sel.gy, sel.gx, sel.col, sel.row};
    assign o_free   = (r_v == '0) || (fire && (rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_load) begin
            r_v <= i_valid;
        end else if (fire) begin
            r_v <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/core/masked_image_gradient_unit.sv
// Masked image gradient unit. Pixels arrive in raster order, one word per pixel with three
// signed 16-bit channels and a mask flag in tuser; for every masked pixel one result word
// carries its row, column and the x and y gradients of each channel in half steps (central
// difference with both neighbors in frame and mask, doubled one-sided difference with one,
// zero with none). Results leave one row behind the input, except on the last row, which
// is emitted as it streams in; tlast marks the final result caused by a pixel. An accepted
// pixel first reads the two line memories (1024 x 49 bits each, read-modify-write with
// forwarding from the previous write), then passes the gradient stage that loads the output
// register. The input takes one pixel per cycle while each pixel causes at most one result
// and the output is not stalled; the output register sends one result per cycle while
// m_axis_tready is high, so a last-row pixel that causes two or three results holds the
// input until they have left. The line memories need no clearing pass; they are valid once
// a frame row has streamed through. Width and height are written through the configuration
// port while the unit is idle; zero reads as one and values above 1024 as 1024.
`timescale 1ns / 1ps
`include "masked_image_gradient_unit_defines.svh"

module masked_image_gradient_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mig_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mig_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mig_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // chan_zero, chan_one, chan_two
    input  logic                            s_axis_tuser,  // inside_req
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pix_row, pix_col, gx_zero, gx_one, gx_two, gy_zero, gy_one, gy_two
    output logic [mig_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast   // last_of_run
);

    mig_pkg::t_pos pos;
    mig_pkg::t_pix cur;
    logic          accept;
    logic          s1_adv;
    logic          out_free;

    logic          r_s1_v;
    mig_pkg::t_pos r_s1_pos;
    mig_pkg::t_pix r_s1_cur;
    mig_pkg::t_pix r_rec0;
    mig_pkg::t_pix r_rec1;

    logic          r_wr_v;
    mig_pkg::t_col r_wr_addr;
    mig_pkg::t_pix r_wr_prev;
    mig_pkg::t_pix r_wr_old;

    mig_pkg::t_col ra_right;
    mig_pkg::t_col ra_left;
    mig_pkg::t_col s1_right;
    mig_pkg::t_col s1_left;

    mig_pkg::t_pix prev_rd0;
    mig_pkg::t_pix prev_rd1;
    mig_pkg::t_pix old_rd0;
    mig_pkg::t_pix old_rd1;
    mig_pkg::t_pix prev_c;
    mig_pkg::t_pix prev_r;
    mig_pkg::t_pix old_c;
    mig_pkg::t_pix old_l;

    mig_pkg::t_pout row_out;
    mig_pkg::t_pout row_up;
    mig_pkg::t_pout col_out;
    mig_pkg::t_pout col_lf;

    logic [mig_pkg::EMITS-1:0]          emit_v;
    mig_pkg::t_res [mig_pkg::EMITS-1:0] emit_res;

    assign s_axis_tready = !r_s1_v || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_adv        = r_s1_v && out_free;

    always_comb begin
        cur      = '0;
        cur.mask = s_axis_tuser;
        for (int k = 0; k < mig_pkg::IN_USE; k++) begin
            cur.ch[k] = mig_pkg::t_chan'(mig_pkg::t_inext'(
                s_axis_tdata[k*mig_pkg::IN_CH_W +: mig_pkg::IN_CH_W]));
        end
    end

    mig_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .o_pos      (pos)
    );

    assign ra_right = pos.col + mig_pkg::t_col'(1);
    assign ra_left  = pos.col - mig_pkg::t_col'(1);

    // Row r-1 at each column; the write puts the current pixel in.
    mig_ram #(
        .WIDTH (mig_pkg::PIX_W),
        .DEPTH (mig_pkg::MAX_WIDTH)
    ) u_prev_ram (
        .i_clk (i_clk),
        .i_we  (s1_adv),
        .i_wa  (r_s1_pos.col),
        .i_wd  (r_s1_cur),
        .i_re  (accept),
        .i_ra0 (pos.col),
        .i_ra1 (ra_right),
        .o_rd0 (prev_rd0),
        .o_rd1 (prev_rd1)
    );

    // Row r-2 at each column; the write moves the old row r-1 word down.
    mig_ram #(
        .WIDTH (mig_pkg::PIX_W),
        .DEPTH (mig_pkg::MAX_WIDTH)
    ) u_older_ram (
        .i_clk (i_clk),
        .i_we  (s1_adv),
        .i_wa  (r_s1_pos.col),
        .i_wd  (prev_c),
        .i_re  (accept),
        .i_ra0 (pos.col),
        .i_ra1 (ra_left),
        .o_rd0 (old_rd0),
        .o_rd1 (old_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= pos;
            r_s1_cur <= cur;
        end
    end

    // Track the last write; the read issued at that same edge saw the old word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v <= 1'b0;
        end else if (s1_adv) begin
            r_wr_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_wr_addr <= r_s1_pos.col;
            r_wr_prev <= r_s1_cur;
            r_wr_old  <= prev_c;
            r_rec1    <= r_rec0;
            r_rec0    <= r_s1_cur;
        end
    end

    assign s1_right = r_s1_pos.col + mig_pkg::t_col'(1);
    assign s1_left  = r_s1_pos.col - mig_pkg::t_col'(1);

    assign prev_c = (r_wr_v && (r_wr_addr == r_s1_pos.col)) ? r_wr_prev : prev_rd0;
    assign prev_r = (r_wr_v && (r_wr_addr == s1_right))     ? r_wr_prev : prev_rd1;
    assign old_c  = (r_wr_v && (r_wr_addr == r_s1_pos.col)) ? r_wr_old  : old_rd0;
    assign old_l  = (r_wr_v && (r_wr_addr == s1_left))      ? r_wr_old  : old_rd1;

    assign row_out = mig_pkg::t_pout'(r_s1_pos.row);
    assign row_up  = mig_pkg::t_pout'(r_s1_pos.row - mig_pkg::t_row'(1));
    assign col_out = mig_pkg::t_pout'(r_s1_pos.col);
    assign col_lf  = mig_pkg::t_pout'(s1_left);

    // Pixel one row up, completed by the current pixel below it.
    assign emit_v[0] = r_s1_pos.row_ge1 && prev_c.mask;
    mig_grad u_grad_up (
        .i_mid       (prev_c),
        .i_left      (old_l),
        .i_right     (prev_r),
        .i_top       (old_c),
        .i_bottom    (r_s1_cur),
        .i_left_ok   (r_s1_pos.has_left),
        .i_right_ok  (r_s1_pos.has_right),
        .i_top_ok    (r_s1_pos.row_ge2),
        .i_bottom_ok (1'b1),
        .i_row       (row_up),
        .i_col       (col_out),
        .o_res       (emit_res[0])
    );

    // Last row: the pixel to the left, completed by the current pixel.
    assign emit_v[1] = r_s1_pos.last_row && r_s1_pos.has_left && r_rec0.mask;
    mig_grad u_grad_left (
        .i_mid       (r_rec0),
        .i_left      (r_rec1),
        .i_right     (r_s1_cur),
        .i_top       (old_l),
        .i_bottom    (r_s1_cur),
        .i_left_ok   (r_s1_pos.has_left2),
        .i_right_ok  (1'b1),
        .i_top_ok    (r_s1_pos.row_ge1),
        .i_bottom_ok (1'b0),
        .i_row       (row_out),
        .i_col       (col_lf),
        .o_res       (emit_res[1])
    );

    // Last row, last column: the current pixel itself.
    assign emit_v[2] = r_s1_pos.last_row && r_s1_pos.last_col && r_s1_cur.mask;
    mig_grad u_grad_self (
        .i_mid       (r_s1_cur),
        .i_left      (r_rec0),
        .i_right     (r_s1_cur),
        .i_top       (prev_c),
        .i_bottom    (r_s1_cur),
        .i_left_ok   (r_s1_pos.has_left),
        .i_right_ok  (1'b0),
        .i_top_ok    (r_s1_pos.row_ge1),
        .i_bottom_ok (1'b0),
        .i_row       (row_out),
        .i_col       (col_out),
        .o_res       (emit_res[2])
    );

    mig_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_adv),
        .i_valid  (emit_v),
        .i_res    (emit_res),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    `MIG_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, accept, r_s1_v)
    `MIG_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_s1_v && !s1_adv, r_s1_v && $stable(r_s1_pos))
    `MIG_ASSERT_NXT(a_commit_shows, i_clk, i_rst_n, s1_adv && (emit_v != '0), m_axis_tvalid)

endmodule
